// ===== src/lgg_pkg.sv =====
// constants, register codes and types shared by the life grid stream modules
// no dependencies
package lgg_pkg;

  localparam int unsigned MAX_WIDTH  = 128;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned GW_W   = 8;
  localparam int unsigned GH_W   = 11;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned IDX_W  = 1;
  localparam int unsigned WIN_W  = 9;
  localparam int unsigned CNT_W  = 4;

  localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [GW_W-1:0] GRID_WIDTH_RST  = GW_W'(120);
  localparam logic [GH_W-1:0] GRID_HEIGHT_RST = GH_W'(30);
  localparam logic [GW_W-1:0] GRID_WIDTH_MIN  = GW_W'(3);
  localparam logic [GW_W-1:0] GRID_WIDTH_MAX  = GW_W'(MAX_WIDTH);
  localparam logic [GH_W-1:0] GRID_HEIGHT_MIN = GH_W'(3);
  localparam logic [GH_W-1:0] GRID_HEIGHT_MAX = GH_W'(MAX_HEIGHT);

  // window layout: three column triplets, oldest (left) in bits 2..0,
  // each triplet holds top in bit 0, middle in bit 1, bottom in bit 2
  localparam logic [WIN_W-1:0] MASK_LEFT   = 9'h007;
  localparam logic [WIN_W-1:0] MASK_RIGHT  = 9'h1C0;
  localparam logic [WIN_W-1:0] MASK_TOP    = 9'h049;
  localparam logic [WIN_W-1:0] MASK_BOTTOM = 9'h124;
  localparam logic [WIN_W-1:0] MASK_CENTER = 9'h010;
  localparam int unsigned      CENTER_BIT  = 4;

  localparam logic [CNT_W-1:0] BIRTH_COUNT   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURVIVE_COUNT = CNT_W'(2);

  // which sides of the reported cell lie outside the grid
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } edge_flags_t;

endpackage

// ===== src/life_grid_generation_stream.sv =====
// Streaming next-generation stencil (B3/S23) on a bounded grid.
// Cells arrive in raster order, one alive bit per request on the input
// channel (in_valid_i / in_stall_o). Each result carries the next state of
// one cell with its column, row and a last-of-frame flag on the output
// channel (out_valid_o / out_stall_i). Frames follow one another without
// gaps; feeding the next frame pushes out the tail of the previous one.
// The result for a cell leaves grid_width+1 requests after the cell was
// taken; the first grid_width+1 requests after reset or a register write
// give no result, every later request gives exactly one.
// Throughput is one request per clock while in_stall_o is low: the line
// buffer is read one column ahead, so the window update and the neighbor
// count are combinational between acceptance and the output register.
// out_valid_o rises in the cycle after acceptance of the completing request.
// While the output register is full and stalled, in_stall_o is high.
// Reset restores grid_width 120 and grid_height 30 and restarts the stream
// at row 0, column 0. A register write (index 0 width, 1 height, values
// saturated to 3..128 and 3..1024) restarts the stream the same way.
// depends on lgg_pkg, lgg_line_buf, lgg_cell_rule
module life_grid_generation_stream import lgg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cell_alive_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             next_alive_o,
  output logic [COL_W-1:0] cell_col_o,
  output logic [ROW_W-1:0] cell_row_o,
  output logic             frame_last_o
);

  logic [GW_W-1:0]  width_q;
  logic [GH_W-1:0]  height_q;
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic             primed_q, primed_d;
  logic [WIN_W-1:0] win_q, win_d;

  logic             out_valid_q;
  logic             next_alive_q;
  logic [COL_W-1:0] cell_col_q;
  logic [ROW_W-1:0] cell_row_q;
  logic             frame_last_q;

  logic             in_acc;
  logic [1:0]       stored;
  logic [2:0]       triplet;
  logic [1:0]       wr_data;
  logic [GW_W-1:0]  col_inc;
  logic [GH_W-1:0]  row_inc;
  logic [GH_W-1:0]  rep_row_w;
  logic [COL_W-1:0] rep_col;
  logic [ROW_W-1:0] rep_row;
  edge_flags_t      edges;
  logic             alive;
  logic [GW_W-1:0]  cfg_w_raw;
  logic [GW_W-1:0]  cfg_w_sat;
  logic [GH_W-1:0]  cfg_h_sat;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // saturate register values at write time
  always_comb begin
    cfg_w_raw = cfg_data_i[GW_W-1:0];
    if (cfg_w_raw < GRID_WIDTH_MIN) begin
      cfg_w_sat = GRID_WIDTH_MIN;
    end else if (cfg_w_raw > GRID_WIDTH_MAX) begin
      cfg_w_sat = GRID_WIDTH_MAX;
    end else begin
      cfg_w_sat = cfg_w_raw;
    end
    if (cfg_data_i < GRID_HEIGHT_MIN) begin
      cfg_h_sat = GRID_HEIGHT_MIN;
    end else if (cfg_data_i > GRID_HEIGHT_MAX) begin
      cfg_h_sat = GRID_HEIGHT_MAX;
    end else begin
      cfg_h_sat = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= GRID_WIDTH_RST;
      height_q <= GRID_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH:  width_q  <= cfg_w_sat;
        REG_GRID_HEIGHT: height_q <= cfg_h_sat;
        default: ;
      endcase
    end
  end

  // new column of the window: bit0 two rows up, bit1 one row up, bit2 now
  assign triplet = {cell_alive_i, stored[0], stored[1]};
  assign wr_data = {stored[0], cell_alive_i};

  always_comb begin
    win_d    = {triplet, win_q[WIN_W-1:3]};
    primed_d = primed_q | (in_row_q >= ROW_W'(2)) |
               ((in_row_q == ROW_W'(1)) && (in_col_q != '0));

    // position of the cell the window is centered on
    if (in_col_q != '0) begin
      rep_col = in_col_q - COL_W'(1);
      if (in_row_q != '0) begin
        rep_row_w = GH_W'(in_row_q) - GH_W'(1);
      end else begin
        rep_row_w = height_q - GH_W'(1);
      end
    end else begin
      rep_col = COL_W'(width_q - GW_W'(1));
      if (in_row_q >= ROW_W'(2)) begin
        rep_row_w = GH_W'(in_row_q) - GH_W'(2);
      end else begin
        rep_row_w = GH_W'(in_row_q) + height_q - GH_W'(2);
      end
    end
    rep_row = rep_row_w[ROW_W-1:0];

    // raster position of the next request
    col_inc = GW_W'(in_col_q) + GW_W'(1);
    row_inc = GH_W'(in_row_q) + GH_W'(1);
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (cfg_we_i) begin
      in_col_d = '0;
      in_row_d = '0;
    end else if (in_acc) begin
      if (col_inc >= width_q) begin
        in_col_d = '0;
        if (row_inc >= height_q) begin
          in_row_d = '0;
        end else begin
          in_row_d = row_inc[ROW_W-1:0];
        end
      end else begin
        in_col_d = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    edges.left   = (rep_col == '0);
    edges.right  = (GW_W'(rep_col) == width_q - GW_W'(1));
    edges.top    = (rep_row == '0);
    edges.bottom = (GH_W'(rep_row) == height_q - GH_W'(1));
  end

  lgg_line_buf u_line_buf (
    .clk_i     (clk_i),
    .we_i      (in_acc),
    .wr_addr_i (in_col_q),
    .wr_data_i (wr_data),
    .rd_addr_i (in_col_d),
    .rd_data_o (stored)
  );

  lgg_cell_rule u_cell_rule (
    .window_i (win_d),
    .edges_i  (edges),
    .alive_o  (alive)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      primed_q <= 1'b0;
      win_q    <= '0;
    end else if (cfg_we_i) begin
      in_col_q <= '0;
      in_row_q <= '0;
      primed_q <= 1'b0;
      win_q    <= '0;
    end else if (in_acc) begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      primed_q <= primed_d;
      win_q    <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= primed_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      next_alive_q <= alive;
      cell_col_q   <= rep_col;
      cell_row_q   <= rep_row;
      frame_last_q <= edges.right & edges.bottom;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign next_alive_o = next_alive_q;
  assign cell_col_o   = cell_col_q;
  assign cell_row_o   = cell_row_q;
  assign frame_last_o = frame_last_q;

endmodule

// ===== src/lgg_line_buf.sv =====
// two-row line buffer, one 2-bit entry per column, registered read
// depends on lgg_pkg
module lgg_line_buf import lgg_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  logic [1:0]       wr_data_i,
  input  logic [COL_W-1:0] rd_addr_i,
  output logic [1:0]       rd_data_o
);

  logic [1:0] mem_q [MAX_WIDTH];
  logic [1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // address is the column of the next request, never the one being written
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/lgg_cell_rule.sv =====
// neighbor count over the masked 3x3 window and the B3/S23 decision
// depends on lgg_pkg
module lgg_cell_rule import lgg_pkg::*; (
  input  logic [WIN_W-1:0] window_i,
  input  edge_flags_t      edges_i,
  output logic             alive_o
);

  logic [WIN_W-1:0] mask;
  logic [WIN_W-1:0] nbrs;
  logic [CNT_W-1:0] count;

  always_comb begin
    mask = ~MASK_CENTER;
    if (edges_i.left)   mask = mask & ~MASK_LEFT;
    if (edges_i.right)  mask = mask & ~MASK_RIGHT;
    if (edges_i.top)    mask = mask & ~MASK_TOP;
    if (edges_i.bottom) mask = mask & ~MASK_BOTTOM;
    nbrs = window_i & mask;
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < WIN_W; i++) begin
      count = count + CNT_W'(nbrs[i]);
    end
  end

  always_comb begin
    if (window_i[CENTER_BIT]) begin
      alive_o = (count == SURVIVE_COUNT) || (count == BIRTH_COUNT);
    end else begin
      alive_o = (count == BIRTH_COUNT);
    end
  end

endmodule

// ===== tb/life_grid_generation_stream_test.sv =====
`timescale 1ns / 100ps
// self-checking bench for life_grid_generation_stream: raster cells in, B3/S23 results out
// results are predicted by a line-buffer model in the scoreboard class; depends on lgg_pkg
module life_grid_generation_stream_test;
  import lgg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic             next_alive;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } cell_report_t;

  class life_next_gen_board;
    logic [1:0]       upper_rows [MAX_WIDTH];  // bit0 one row up, bit1 two rows up
    logic [WIN_W-1:0] win;
    int unsigned      next_col;
    int unsigned      next_row;
    bit               primed;
    logic [GW_W-1:0]  width_reg;
    logic [GH_W-1:0]  height_reg;
    cell_report_t     due[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      frames;
    int unsigned      alive_seen;

    function new();
      width_reg  = GRID_WIDTH_RST;
      height_reg = GRID_HEIGHT_RST;
      foreach (upper_rows[i]) upper_rows[i] = 2'b00;
      errors     = 0;
      checked    = 0;
      frames     = 0;
      alive_seen = 0;
      restart();
    endfunction

    function void restart();
      win      = '0;
      next_col = 0;
      next_row = 0;
      primed   = 1'b0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_GRID_WIDTH) begin
        width_reg = data[GW_W-1:0];
      end else if (idx == REG_GRID_HEIGHT) begin
        height_reg = data[GH_W-1:0];
      end
      restart();
    endfunction

    function void take_cell(logic alive);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      int unsigned      r;
      int unsigned      col;
      int unsigned      row;
      int unsigned      nb;
      logic [1:0]       stored;
      logic [WIN_W-1:0] mask;
      cell_report_t     rep;
      w = (width_reg < GRID_WIDTH_MIN) ? GRID_WIDTH_MIN :
          (width_reg > GRID_WIDTH_MAX) ? GRID_WIDTH_MAX : width_reg;
      h = (height_reg < GRID_HEIGHT_MIN) ? GRID_HEIGHT_MIN :
          (height_reg > GRID_HEIGHT_MAX) ? GRID_HEIGHT_MAX : height_reg;
      c = (next_col >= w) ? 0 : next_col;
      r = (next_row >= h) ? 0 : next_row;
      stored = upper_rows[c];
      // new column enters on the right: bottom, middle, top
      win = {alive, stored[0], stored[1], win[WIN_W-1:3]};
      upper_rows[c] = {stored[0], alive};
      if (!primed && (r >= 2 || (r == 1 && c >= 1))) primed = 1'b1;
      // reported cell sits one column and one row behind the input
      if (c >= 1) begin
        col = c - 1;
        row = (r >= 1) ? r - 1 : h - 1;
      end else begin
        col = w - 1;
        row = (r >= 2) ? r - 2 : r + h - 2;
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      next_col = c;
      next_row = r;
      if (!primed) return;
      mask = ~MASK_CENTER;
      if (col == 0) mask &= ~MASK_LEFT;
      if (col == w - 1) mask &= ~MASK_RIGHT;
      if (row == 0) mask &= ~MASK_TOP;
      if (row == h - 1) mask &= ~MASK_BOTTOM;
      nb = $countones(win & mask);
      rep.next_alive = win[CENTER_BIT] ? (nb == SURVIVE_COUNT || nb == BIRTH_COUNT)
                                       : (nb == BIRTH_COUNT);
      rep.col  = col[COL_W-1:0];
      rep.row  = row[ROW_W-1:0];
      rep.last = (row == h - 1 && col == w - 1);
      due.push_back(rep);
    endfunction

    function void check_cell(logic next_alive, logic [COL_W-1:0] col,
                             logic [ROW_W-1:0] row, logic last);
      cell_report_t want;
      cell_report_t got;
      got = '{next_alive, col, row, last};
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: alive %0b col %0d row %0d last %0b",
                 $time, next_alive, col, row, last);
        return;
      end
      want = due.pop_front();
      checked++;
      if (last) frames++;
      if (next_alive) alive_seen++;
      if (got !== want) begin
        errors++;
        $display("%0t: result mismatch: expected alive %0b col %0d row %0d last %0b",
                 $time, want.next_alive, want.col, want.row, want.last);
        $display("%0t:                  actual   alive %0b col %0d row %0d last %0b",
                 $time, next_alive, col, row, last);
      end
    endfunction
  endclass

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             cfg_we_i     = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i    = '0;
  logic [CFG_W-1:0] cfg_data_i   = '0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic             cell_alive_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic             next_alive_o;
  logic [COL_W-1:0] cell_col_o;
  logic [ROW_W-1:0] cell_row_o;
  logic             frame_last_o;

  life_next_gen_board board = new();

  int unsigned cycles      = 0;
  int unsigned cells_in    = 0;
  int unsigned settings    = 0;
  int          burst_left  = 0;
  bit          idle_on     = 1'b0;
  int          stall_mode  = 0;
  int          stall_left  = 0;

  life_grid_generation_stream i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_alive_i (cell_alive_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .next_alive_o (next_alive_o),
    .cell_col_o   (cell_col_o),
    .cell_row_o   (cell_row_o),
    .frame_last_o (frame_last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: randomly switches between stall modes
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(3);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(3) == 0);
      2: out_stall_i <= ($urandom_range(1) == 0);
      default: out_stall_i <= ((stall_left % 16) < 11);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_cell(next_alive_o, cell_col_o, cell_row_o, frame_last_o);
    end
  end

  task automatic send_cell(input logic alive);
    int gap;
    gap = 0;
    if (idle_on && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cell_alive_i <= alive;
    do @(posedge clk_i); while (in_stall_o);
    board.take_cell(alive);
    cells_in++;
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w_data, input logic [CFG_W-1:0] h_data,
                           input int which, input int n, input bit pause_mid);
    int density;
    drain();
    if (which[0]) write_reg(REG_GRID_WIDTH, w_data);
    if (which[1]) write_reg(REG_GRID_HEIGHT, h_data);
    settings++;
    idle_on    = ($urandom_range(3) != 0);
    burst_left = 0;
    density    = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) begin
        case ($urandom_range(5))
          0: density = 0;
          1: density = 15;
          2: density = 35;
          3: density = 50;
          4: density = 80;
          default: density = 100;
        endcase
      end
      if (pause_mid && k == n / 2) drain();
      send_cell($urandom_range(99) < density);
    end
  endtask

  // 3x3 grid: vertical blinker, then a full block, then the head of a dead frame
  task automatic run_directed();
    logic [0:21] shapes;
    shapes = 22'b0100100101111111110000;
    drain();
    write_reg(REG_GRID_WIDTH, 11'd0);
    write_reg(REG_GRID_HEIGHT, 11'd0);
    settings++;
    idle_on = 1'b0;
    for (int k = 0; k < 22; k++) send_cell(shapes[k]);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_phase(11'd0, 11'd0, 0, 130, 1'b0);          // size left at reset values
    run_directed();
    run_phase(11'd4,    11'd4,    3,  85, 1'b0);
    run_phase(11'h700,  11'd0,    3,  58, 1'b0);    // upper data bits ignored
    run_phase(11'd5,    11'd7,    3, 146, 1'b1);
    run_phase(11'h0FF,  11'd3,    3, 400, 1'b0);
    run_phase(11'd16,   11'd8,    3, 200, 1'b1);
    run_phase(11'd3,    11'h7FF,  3, 150, 1'b0);
    run_phase(11'd0,    11'd5,    2,  94, 1'b0);    // height only
    run_phase(11'd200,  11'd0,    1, 160, 1'b0);    // width only
    run_phase(11'd10,   11'd6,    3, 191, 1'b0);
    run_phase(11'd2,    11'd4,    3,  64, 1'b0);
    run_phase(11'd128,  11'd1024, 3, 160, 1'b0);
    drain();

    $display("fed %0d cells over %0d grid settings, checked %0d results",
             cells_in, settings, board.checked);
    $display("%0d results alive, %0d complete frames, %0d errors",
             board.alive_seen, board.frames, board.errors);
    if (board.errors == 0 && board.due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
